// File: rtl/core/sktab_pkg.sv
// Shared types and constants for the sorted key table.
// No dependencies.
package sktab_pkg;

   localparam int unsigned DefCapacity    = 256;
   localparam int unsigned DefPayloadBits = 64;
   localparam int unsigned KeyBits        = 32;
   localparam int unsigned RevBits        = 32;
   localparam int unsigned CntBits        = 32;
   localparam int unsigned StatusBits     = 3;
   localparam int unsigned PosBits        = 9;
   localparam int unsigned ReqBits        = 2;

   localparam logic [ReqBits-1:0] REQ_UPSERT = 2'd0;
   localparam logic [ReqBits-1:0] REQ_REMOVE = 2'd1;

   localparam logic [StatusBits-1:0] ST_UPDATED   = 3'd0;
   localparam logic [StatusBits-1:0] ST_ADDED     = 3'd1;
   localparam logic [StatusBits-1:0] ST_REMOVED   = 3'd2;
   localparam logic [StatusBits-1:0] ST_FOUND     = 3'd3;
   localparam logic [StatusBits-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [StatusBits-1:0] ST_ZERO_KEY  = 3'd5;
   localparam logic [StatusBits-1:0] ST_DISABLED  = 3'd6;
   localparam logic [StatusBits-1:0] ST_FULL      = 3'd7;

   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_PROBE   = 10'b0000000010,
      S_CMP     = 10'b0000000100,
      S_HITRD   = 10'b0000001000,
      S_HITCHK  = 10'b0000010000,
      S_DECIDE  = 10'b0000100000,
      S_SHRD    = 10'b0001000000,
      S_SHWR    = 10'b0010000000,
      S_FINAL   = 10'b0100000000,
      S_OUT     = 10'b1000000000
   } state_type;

endpackage

// File: rtl/core/sorted_key_table_upsert_remove_find.sv
// Sorted key table top level: sequencer, search and shift logic, counters.
// Depends on sktab_pkg and sktab_ram.
//
// Usage: a request word (req_type, key, req_entry_payload) is taken when
// req_valid is high and req_stall low. The table holds CAPACITY records sorted
// by key. Each enabled request with a nonzero key first runs a binary
// lower-bound search, each probe reading the key memory through its read port.
// An insert then shifts the higher entries up, a remove shifts them down, each
// moved entry read through the read port and written through the write port.
// One request is in work at a time; req_stall is high from acceptance until
// the response word has been taken. The response stays on rsp_* with
// rsp_valid high until rsp_stall is low. Reset clears counters and disables
// the block. Any write to csr_block_enabled empties the table and clears all
// counters.
module sorted_key_table_upsert_remove_find import sktab_pkg::*; #(
   parameter int unsigned CAPACITY     = DefCapacity,
   parameter int unsigned PAYLOAD_BITS = DefPayloadBits
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_block_enabled,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ReqBits-1:0]    req_type,
   input  logic [KeyBits-1:0]    req_key,
   input  logic [63:0]           req_entry_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [StatusBits-1:0] rsp_status,
   output logic [63:0]           rsp_found_payload,
   output logic [RevBits-1:0]    rsp_record_revision,
   output logic [PosBits-1:0]    rsp_position,
   output logic [PosBits-1:0]    rsp_entry_count,
   output logic [CntBits-1:0]    rsp_table_revision,
   output logic [CntBits-1:0]    rsp_added_total,
   output logic [CntBits-1:0]    rsp_updated_total,
   output logic [CntBits-1:0]    rsp_removed_total
);
   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned PW = PAYLOAD_BITS;

   state_type state_ff, state_in;
   logic enabled_ff, enabled_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CntBits-1:0] grev_ff, grev_in, ins_ff, ins_in, upd_ff, upd_in, rem_ff, rem_in;

   logic [ReqBits-1:0] op_ff, op_in;
   logic [KeyBits-1:0] key_ff, key_in;
   logic [PW-1:0] pay_ff, pay_in;
   logic [CW-1:0] first_ff, first_in, span_ff, span_in, idx_ff, idx_in;
   logic hit_ff, hit_in;

   logic [StatusBits-1:0] st_ff, st_in;
   logic [PW-1:0] rpay_ff, rpay_in;
   logic [RevBits-1:0] rrev_ff, rrev_in;

   // memory ports
   logic we;
   logic [AW-1:0] wa, ra;
   logic [KeyBits-1:0] wkey, rkey;
   logic [PW-1:0] wpay, rpay;
   logic [RevBits-1:0] wrev, rrev;

   sktab_ram #(.WIDTH(KeyBits), .DEPTH(CAPACITY)) u_key (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wkey), .rd_addr(ra), .rd_data(rkey));
   sktab_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_pay (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wpay), .rd_addr(ra), .rd_data(rpay));
   sktab_ram #(.WIDTH(RevBits), .DEPTH(CAPACITY)) u_rev (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wrev), .rd_addr(ra), .rd_data(rrev));

   logic [CW-1:0] half, probe;
   assign half  = span_ff >> 1;
   assign probe = first_ff + half;

   always_comb begin
      state_in = state_ff;
      enabled_in = enabled_ff;
      count_in = count_ff;
      grev_in = grev_ff; ins_in = ins_ff; upd_in = upd_ff; rem_in = rem_ff;
      op_in = op_ff; key_in = key_ff; pay_in = pay_ff;
      first_in = first_ff; span_in = span_ff; idx_in = idx_ff; hit_in = hit_ff;
      st_in = st_ff; rpay_in = rpay_ff; rrev_in = rrev_ff;
      we = 1'b0;
      wa = idx_ff[AW-1:0];
      ra = idx_ff[AW-1:0];
      wkey = rkey; wpay = rpay; wrev = rrev;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_type;
               key_in = req_key;
               pay_in = req_entry_payload[PW-1:0];
               first_in = '0;
               span_in = count_ff;
               rpay_in = '0;
               rrev_in = '0;
               hit_in = 1'b0;
               if (!enabled_ff) begin
                  st_in = ST_DISABLED;
                  state_in = S_OUT;
               end else if (req_key == '0) begin
                  st_in = ST_ZERO_KEY;
                  state_in = S_OUT;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (span_ff == '0) begin
               state_in = S_HITRD;
            end else begin
               ra = probe[AW-1:0];
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (rkey < key_ff) begin
               first_in = probe + 1'b1;
               span_in = span_ff - half - 1'b1;
            end else begin
               span_in = half;
            end
            state_in = S_PROBE;
         end
         S_HITRD: begin
            // read the lower-bound entry
            ra = first_ff[AW-1:0];
            state_in = S_HITCHK;
         end
         S_HITCHK: begin
            // hold the address so payload and revision stay valid for the decision
            ra = first_ff[AW-1:0];
            hit_in = (first_ff < count_ff) && (rkey == key_ff);
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (op_ff == REQ_UPSERT) begin
               if (hit_ff) begin
                  we = 1'b1;
                  wa = first_ff[AW-1:0];
                  wkey = key_ff;
                  wpay = pay_ff;
                  wrev = rrev + 1'b1;
                  rpay_in = pay_ff;
                  rrev_in = rrev + 1'b1;
                  upd_in = upd_ff + 1'b1;
                  grev_in = grev_ff + 1'b1;
                  st_in = ST_UPDATED;
                  state_in = S_OUT;
               end else if (count_ff >= CW'(CAPACITY)) begin
                  st_in = ST_FULL;
                  state_in = S_OUT;
               end else begin
                  idx_in = count_ff;
                  state_in = S_SHRD;
               end
            end else if (op_ff == REQ_REMOVE) begin
               if (hit_ff) begin
                  rpay_in = rpay;
                  rrev_in = rrev;
                  idx_in = first_ff;
                  state_in = S_SHRD;
               end else begin
                  st_in = ST_NOT_FOUND;
                  state_in = S_OUT;
               end
            end else begin
               if (hit_ff) begin
                  rpay_in = rpay;
                  rrev_in = rrev;
                  st_in = ST_FOUND;
               end else begin
                  st_in = ST_NOT_FOUND;
               end
               state_in = S_OUT;
            end
         end
         S_SHRD: begin
            // insert moves idx-1 to idx, remove moves idx+1 to idx
            if (op_ff == REQ_UPSERT) begin
               if (idx_ff == first_ff) begin
                  state_in = S_FINAL;
               end else begin
                  ra = AW'(idx_ff - 1'b1);
                  state_in = S_SHWR;
               end
            end else begin
               if (CW'(idx_ff + 1'b1) >= count_ff) begin
                  state_in = S_FINAL;
               end else begin
                  ra = AW'(idx_ff + 1'b1);
                  state_in = S_SHWR;
               end
            end
         end
         S_SHWR: begin
            we = 1'b1;
            idx_in = (op_ff == REQ_UPSERT) ? idx_ff - 1'b1 : idx_ff + 1'b1;
            state_in = S_SHRD;
         end
         S_FINAL: begin
            grev_in = grev_ff + 1'b1;
            if (op_ff == REQ_UPSERT) begin
               we = 1'b1;
               wa = first_ff[AW-1:0];
               wkey = key_ff;
               wpay = pay_ff;
               wrev = RevBits'(1);
               rpay_in = pay_ff;
               rrev_in = RevBits'(1);
               count_in = count_ff + 1'b1;
               ins_in = ins_ff + 1'b1;
               st_in = ST_ADDED;
            end else begin
               count_in = count_ff - 1'b1;
               rem_in = rem_ff + 1'b1;
               st_in = ST_REMOVED;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_wr_en) begin
         enabled_in = csr_block_enabled;
         count_in = '0;
         grev_in = '0; ins_in = '0; upd_in = '0; rem_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         enabled_ff <= 1'b0;
         count_ff <= '0;
         grev_ff <= '0; ins_ff <= '0; upd_ff <= '0; rem_ff <= '0;
      end else begin
         state_ff <= state_in;
         enabled_ff <= enabled_in;
         count_ff <= count_in;
         grev_ff <= grev_in; ins_ff <= ins_in; upd_ff <= upd_in; rem_ff <= rem_in;
      end
      op_ff <= op_in; key_ff <= key_in; pay_ff <= pay_in;
      first_ff <= first_in; span_ff <= span_in; idx_ff <= idx_in; hit_ff <= hit_in;
      st_ff <= st_in; rpay_ff <= rpay_in; rrev_ff <= rrev_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_status = st_ff;
   assign rsp_found_payload = 64'(rpay_ff);
   assign rsp_record_revision = rrev_ff;
   assign rsp_position = (st_ff == ST_DISABLED || st_ff == ST_ZERO_KEY) ? '0 : PosBits'(first_ff);
   assign rsp_entry_count = PosBits'(count_ff);
   assign rsp_table_revision = grev_ff;
   assign rsp_added_total = ins_ff;
   assign rsp_updated_total = upd_ff;
   assign rsp_removed_total = rem_ff;
endmodule

// File: rtl/core/sktab_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sktab_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
